// File: src/hsv_to_rgb_converter_unit_defines.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define HSVRGB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hsvrgb: assertion failed");
`define HSVRGB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hsvrgb: assertion failed");
`else
`define HSVRGB_ASSERT_SAME(label, clk, rst, ante, cons)
`define HSVRGB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: src/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Widths, constants, stage indices and inter-module types.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  localparam int HUE_W = 10;
  localparam int CH_W  = 8;
  localparam int SEC_W = 5;

  localparam logic [HUE_W-1:0] HUE_LIMIT  = 10'd360;
  localparam logic [HUE_W-1:0] SECTOR_DEG = 10'd60;
  localparam logic [9:0]       FRAC_ONE   = 10'd1000;
  localparam logic [CH_W-1:0]  FULL8      = 8'd255;
  localparam logic [17:0]      FULL_FRAC  = 18'd255000;

  // Reciprocal multipliers; all but FRAC_MUL (slightly over) are slight underestimates so one correction suffices.
  localparam logic [4:0]  SEC_RECIP = 5'd17;           // 1/60 at 2^-10
  localparam logic [8:0]  RECIP255  = 9'd257;          // 1/255 at 2^-16
  localparam logic [21:0] FRAC_MUL  = 22'd2184550;     // 50/3 at 2^-17
  localparam logic [10:0] RECIP1000 = 11'd1048;        // 1/1000 at 2^-20
  localparam logic [14:0] RECIP255K = 15'd16843;       // 1/255000 at 2^-32

  localparam logic [SEC_W-1:0] SEC_R_TO_Y = 5'd0;
  localparam logic [SEC_W-1:0] SEC_Y_TO_G = 5'd1;
  localparam logic [SEC_W-1:0] SEC_G_TO_C = 5'd2;
  localparam logic [SEC_W-1:0] SEC_C_TO_B = 5'd3;
  localparam logic [SEC_W-1:0] SEC_B_TO_M = 5'd4;
  localparam logic [SEC_W-1:0] SEC_M_TO_R = 5'd5;

  localparam int NSTAGE   = 9;
  localparam int ST_IN    = 0;
  localparam int ST_SEC   = 1;
  localparam int ST_FRAC  = 2;
  localparam int ST_PROD  = 3;
  localparam int ST_RECIP = 4;
  localparam int ST_QM    = 5;
  localparam int ST_TV    = 6;
  localparam int ST_TE    = 7;
  localparam int ST_OUT   = 8;

  typedef struct packed {
    logic [NSTAGE-1:0] en;
    logic [NSTAGE-1:0] vld;
  } pipe_ctl_t;

  typedef struct packed {
    logic             grey;
    logic [SEC_W-1:0] sector;
    logic [CH_W-1:0]  s;
    logic [CH_W-1:0]  v;
    logic [15:0]      vs;
    logic [9:0]       frac;
    logic [CH_W-1:0]  p;
  } sec_out_t;

  typedef struct packed {
    logic             grey;
    logic [SEC_W-1:0] sector;
    logic [CH_W-1:0]  v;
    logic [CH_W-1:0]  p;
    logic [CH_W-1:0]  q;
    logic [CH_W-1:0]  m;
  } scale_out_t;

endpackage

// File: src/hsvrgb_ctrl.sv
// ----------------------------------------------------------------------------
// HSV to RGB pipeline control
// Per-stage valid bits and load enables with bubble collapsing.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsvrgb_ctrl import hsvrgb_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      pixel_valid,
  output logic      pixel_stall,
  output logic      color_valid,
  input  logic      color_stall,
  output pipe_ctl_t ctl
);

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;
  logic              acc_in;
  logic              acc_out;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || !color_stall;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= pixel_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign pixel_stall = !en[0];
  assign color_valid = vld[NSTAGE-1];
  assign ctl.en      = en;
  assign ctl.vld     = vld;
  assign acc_in      = pixel_valid && !pixel_stall;
  assign acc_out     = color_valid && !color_stall;

  `HSVRGB_ASSERT_SAME(a_empty_out_ready, clk, rst, !color_valid, !pixel_stall)
  `HSVRGB_ASSERT_NEXT(a_item_count, clk, rst, 1'b1, $countones(vld) == $past($countones(vld)) + int'($past(acc_in)) - int'($past(acc_out)))

endmodule

// File: src/hsvrgb_sector.sv
// ----------------------------------------------------------------------------
// HSV to RGB sector stages
// Hue wrap, sector and fraction in thousandths, and the p level.
// ----------------------------------------------------------------------------
module hsvrgb_sector import hsvrgb_pkg::*; (
  input  logic            clk,
  input  pipe_ctl_t       ctl,
  input  logic [HUE_W-1:0] hue,
  input  logic [CH_W-1:0] saturation,
  input  logic [CH_W-1:0] value,
  output sec_out_t        sec
);

  logic [HUE_W-1:0] hw;
  logic [14:0]      hx;
  logic [HUE_W-1:0] h1;
  logic [SEC_W-1:0] est1;
  logic [CH_W-1:0]  s1, v1;
  logic [15:0]      vs1;
  logic             grey1;

  logic [HUE_W-1:0] rem;
  logic [HUE_W-1:0] rdiff;
  logic             corr;
  logic [23:0]      pe_prod;
  logic [SEC_W-1:0] sector2;
  logic [5:0]       r2;
  logic [CH_W-1:0]  s2, v2, pe2;
  logic [15:0]      vs2;
  logic             grey2;

  logic [26:0]      fprod;
  logic [15:0]      prem;
  logic [CH_W-1:0]  pq;

  assign hw = (hue >= HUE_LIMIT) ? '0 : hue;
  assign hx = 15'(hw) * 15'(SEC_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_IN]) begin
      h1    <= hw;
      est1  <= hx[14:10];
      s1    <= saturation;
      v1    <= value;
      vs1   <= 16'(value) * 16'(saturation);
      grey1 <= (saturation == '0);
    end
  end

  assign rem     = h1 - (HUE_W'(est1) * SECTOR_DEG);
  assign rdiff   = rem - SECTOR_DEG;
  assign corr    = (rem >= SECTOR_DEG);
  assign pe_prod = 24'(vs1) * 24'(RECIP255);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_SEC]) begin
      sector2 <= est1 + SEC_W'(corr);
      r2      <= corr ? rdiff[5:0] : rem[5:0];
      s2      <= s1;
      v2      <= v1;
      vs2     <= vs1;
      pe2     <= pe_prod[23:16];
      grey2   <= grey1;
    end
  end

  assign fprod = 27'(r2) * 27'(FRAC_MUL);
  assign prem  = vs2 - (16'(pe2) * 16'(FULL8));
  assign pq    = pe2 + CH_W'(prem >= 16'(FULL8));

  always_ff @(posedge clk) begin
    if (ctl.en[ST_FRAC]) begin
      sec.grey   <= grey2;
      sec.sector <= sector2;
      sec.s      <= s2;
      sec.v      <= v2;
      sec.vs     <= vs2;
      sec.frac   <= fprod[26:17];
      sec.p      <= v2 - pq;
    end
  end

endmodule

// File: src/hsvrgb_scale.sv
// ----------------------------------------------------------------------------
// HSV to RGB scale stages
// Products and constant divisions that give the q level and the t multiplier.
// ----------------------------------------------------------------------------
module hsvrgb_scale import hsvrgb_pkg::*; (
  input  logic       clk,
  input  pipe_ctl_t  ctl,
  input  sec_out_t   sec,
  output scale_out_t scl
);

  logic [9:0]       om;
  logic [17:0]      a4;
  logic [25:0]      b4;
  logic             grey4, grey5;
  logic [SEC_W-1:0] sector4, sector5;
  logic [CH_W-1:0]  v4, p4, v5, p5;

  logic [28:0]      ap;
  logic [40:0]      bp;
  logic [17:0]      a5;
  logic [25:0]      b5;
  logic [8:0]       ae5, be5;

  logic [17:0]      arem;
  logic [25:0]      brem;
  logic [CH_W-1:0]  da, qb;

  assign om = FRAC_ONE - sec.frac;

  always_ff @(posedge clk) begin
    if (ctl.en[ST_PROD]) begin
      a4      <= 18'(sec.s) * 18'(om);
      b4      <= 26'(sec.vs) * 26'(sec.frac);
      grey4   <= sec.grey;
      sector4 <= sec.sector;
      v4      <= sec.v;
      p4      <= sec.p;
    end
  end

  assign ap = 29'(a4) * 29'(RECIP1000);
  assign bp = 41'(b4) * 41'(RECIP255K);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_RECIP]) begin
      a5      <= a4;
      b5      <= b4;
      ae5     <= ap[28:20];
      be5     <= bp[40:32];
      grey5   <= grey4;
      sector5 <= sector4;
      v5      <= v4;
      p5      <= p4;
    end
  end

  assign arem = a5 - (18'(ae5) * 18'(FRAC_ONE));
  assign brem = b5 - (26'(be5) * 26'(FULL_FRAC));
  assign da   = CH_W'(ae5 + 9'(arem >= 18'(FRAC_ONE)));
  assign qb   = CH_W'(be5 + 9'(brem >= 26'(FULL_FRAC)));

  always_ff @(posedge clk) begin
    if (ctl.en[ST_QM]) begin
      scl.grey   <= grey5;
      scl.sector <= sector5;
      scl.v      <= v5;
      scl.p      <= p5;
      scl.q      <= v5 - qb;
      scl.m      <= FULL8 - da;
    end
  end

endmodule

// File: src/hsvrgb_mix.sv
// ----------------------------------------------------------------------------
// HSV to RGB mix stages
// The t level and the sector selection into the output registers.
// ----------------------------------------------------------------------------
`include "hsv_to_rgb_converter_unit_defines.svh"

module hsvrgb_mix import hsvrgb_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  pipe_ctl_t       ctl,
  input  scale_out_t      scl,
  output logic [CH_W-1:0] red,
  output logic [CH_W-1:0] green,
  output logic [CH_W-1:0] blue
);

  logic [15:0]      tv7, tv8;
  logic             grey7, grey8;
  logic [SEC_W-1:0] sector7, sector8;
  logic [CH_W-1:0]  v7, p7, q7, v8, p8, q8, te8;
  logic [23:0]      tp;
  logic [15:0]      trem;
  logic [CH_W-1:0]  t;
  logic [CH_W-1:0]  red_next, green_next, blue_next;

  always_ff @(posedge clk) begin
    if (ctl.en[ST_TV]) begin
      tv7     <= 16'(scl.v) * 16'(scl.m);
      grey7   <= scl.grey;
      sector7 <= scl.sector;
      v7      <= scl.v;
      p7      <= scl.p;
      q7      <= scl.q;
    end
  end

  assign tp = 24'(tv7) * 24'(RECIP255);

  always_ff @(posedge clk) begin
    if (ctl.en[ST_TE]) begin
      tv8     <= tv7;
      te8     <= tp[23:16];
      grey8   <= grey7;
      sector8 <= sector7;
      v8      <= v7;
      p8      <= p7;
      q8      <= q7;
    end
  end

  assign trem = tv8 - (16'(te8) * 16'(FULL8));
  assign t    = te8 + CH_W'(trem >= 16'(FULL8));

  always_comb begin
    if (grey8) begin
      red_next   = v8;
      green_next = v8;
      blue_next  = v8;
    end else begin
      case (sector8)
        SEC_R_TO_Y: begin
          red_next = v8; green_next = t;  blue_next = p8;
        end
        SEC_Y_TO_G: begin
          red_next = q8; green_next = v8; blue_next = p8;
        end
        SEC_G_TO_C: begin
          red_next = p8; green_next = v8; blue_next = t;
        end
        SEC_C_TO_B: begin
          red_next = p8; green_next = q8; blue_next = v8;
        end
        SEC_B_TO_M: begin
          red_next = t;  green_next = p8; blue_next = v8;
        end
        SEC_M_TO_R: begin
          red_next = v8; green_next = p8; blue_next = q8;
        end
        default: begin
          red_next = '0; green_next = '0; blue_next = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en[ST_OUT]) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

  `HSVRGB_ASSERT_NEXT(a_grey_equal, clk, rst, ctl.en[ST_OUT] && ctl.vld[ST_TE] && grey8, red == green && green == blue)
  `HSVRGB_ASSERT_NEXT(a_wide_sector_black, clk, rst, ctl.en[ST_OUT] && ctl.vld[ST_TE] && !grey8 && sector8 > SEC_M_TO_R, red == '0 && green == '0 && blue == '0)

endmodule

// File: src/hsv_to_rgb_converter_unit.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter unit
// Pipeline: nine register stages; a result waits in the output registers
// while the output is stalled, and is taken when the stall drops.
// Throughput: one transaction per clock cycle while the output is not
// stalled, set by the fully pipelined multiplier stages. Reset clears
// every stage valid bit, so no result is shown.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit import hsvrgb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             pixel_valid,
  output logic             pixel_stall,
  input  logic [HUE_W-1:0] hue,
  input  logic [CH_W-1:0]  saturation,
  input  logic [CH_W-1:0]  value,
  output logic             color_valid,
  input  logic             color_stall,
  output logic [CH_W-1:0]  red,
  output logic [CH_W-1:0]  green,
  output logic [CH_W-1:0]  blue
);

  pipe_ctl_t  ctl;
  sec_out_t   sec;
  scale_out_t scl;

  hsvrgb_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .ctl         (ctl)
  );

  hsvrgb_sector u_sector (
    .clk        (clk),
    .ctl        (ctl),
    .hue        (hue),
    .saturation (saturation),
    .value      (value),
    .sec        (sec)
  );

  hsvrgb_scale u_scale (
    .clk (clk),
    .ctl (ctl),
    .sec (sec),
    .scl (scl)
  );

  hsvrgb_mix u_mix (
    .clk   (clk),
    .rst   (rst),
    .ctl   (ctl),
    .scl   (scl),
    .red   (red),
    .green (green),
    .blue  (blue)
  );

endmodule

// File: tb/tb_hsv_to_rgb_converter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter unit testbench
// Pixels with a hue, a saturation and a value are streamed through the
// converter under several patterns of sender gaps and receiver stalls. Every
// accepted pixel is predicted in the testbench and each colour that the unit
// returns is compared, channel by channel, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_hsv_to_rgb_converter_unit;
  import hsvrgb_pkg::*;

  localparam int RANDOM_PIXELS = 1700;
  localparam int NUM_PHASES    = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } colour_t;

  typedef struct {
    logic [HUE_W-1:0] hue;
    logic [CH_W-1:0]  saturation;
    logic [CH_W-1:0]  value;
    int unsigned      gap_pct;
    int unsigned      stall_pct;
    bit               wait_for_drain;
  } pixel_item_t;

  logic             clk;
  logic             rst;
  logic             pixel_valid;
  logic             pixel_stall;
  logic [HUE_W-1:0] hue;
  logic [CH_W-1:0]  saturation;
  logic [CH_W-1:0]  value;
  logic             color_valid;
  logic             color_stall;
  logic [CH_W-1:0]  red;
  logic [CH_W-1:0]  green;
  logic [CH_W-1:0]  blue;

  pixel_item_t pending_pixels[$];
  colour_t     colours_expected[$];
  pixel_item_t next_pixel;
  colour_t     oldest_colour;
  logic        pixel_taken;
  int unsigned stall_pct;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned pixels_converted;
  int unsigned colours_checked;
  int unsigned wrapped_hues;
  int unsigned grey_pixels;

  hsv_to_rgb_converter_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .hue         (hue),
    .saturation  (saturation),
    .value       (value),
    .color_valid (color_valid),
    .color_stall (color_stall),
    .red         (red),
    .green       (green),
    .blue        (blue)
  );

  always #1 clk = ~clk;

  function automatic colour_t hsv_pixel_to_rgb(logic [HUE_W-1:0] h_in,
                                               logic [CH_W-1:0] s_in,
                                               logic [CH_W-1:0] v_in);
    int unsigned      h;
    int unsigned      s;
    int unsigned      v;
    int unsigned      frac;
    int unsigned      p;
    int unsigned      q;
    int unsigned      t;
    logic [SEC_W-1:0] sector;
    colour_t          rgb;
    h = h_in;
    s = s_in;
    v = v_in;
    if (h >= HUE_LIMIT) begin
      h = 0;
    end
    if (s == 0) begin
      rgb.red   = v_in;
      rgb.green = v_in;
      rgb.blue  = v_in;
      return rgb;
    end
    sector = SEC_W'(h / SECTOR_DEG);
    frac   = h * FRAC_ONE / SECTOR_DEG - sector * FRAC_ONE;
    p      = v - v * s / FULL8;
    q      = v - v * s * frac / FULL_FRAC;
    t      = v * (FULL8 - s * (FRAC_ONE - frac) / FRAC_ONE) / FULL8;
    case (sector)
      SEC_R_TO_Y: rgb = '{v[7:0], t[7:0], p[7:0]};
      SEC_Y_TO_G: rgb = '{q[7:0], v[7:0], p[7:0]};
      SEC_G_TO_C: rgb = '{p[7:0], v[7:0], t[7:0]};
      SEC_C_TO_B: rgb = '{p[7:0], q[7:0], v[7:0]};
      SEC_B_TO_M: rgb = '{t[7:0], p[7:0], v[7:0]};
      SEC_M_TO_R: rgb = '{v[7:0], p[7:0], q[7:0]};
      default:    rgb = '0;
    endcase
    return rgb;
  endfunction

  function automatic bit channel_matches(string name, logic [CH_W-1:0] expected,
                                         logic [CH_W-1:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, got %0d", name, expected, actual);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic queue_pixel(int unsigned h, int unsigned s, int unsigned v,
                             int unsigned gap, int unsigned stall, bit drain);
    pixel_item_t item;
    item.hue            = HUE_W'(h);
    item.saturation     = CH_W'(s);
    item.value          = CH_W'(v);
    item.gap_pct        = gap;
    item.stall_pct      = stall;
    item.wait_for_drain = drain;
    pending_pixels.push_back(item);
  endtask

  task automatic queue_random_pixel(int unsigned gap, int unsigned stall, bit drain);
    int unsigned pick;
    int unsigned h;
    int unsigned s;
    int unsigned v;
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      h = $urandom_range(0, HUE_LIMIT - 1);
    end else if (pick < 85) begin
      h = $urandom_range(HUE_LIMIT, (1 << HUE_W) - 1);
    end else if (pick < 93) begin
      h = $urandom_range(0, 5) * SECTOR_DEG + $urandom_range(0, 1) * (SECTOR_DEG - 1);
    end else begin
      h = $urandom_range(0, (1 << HUE_W) - 1);
    end
    pick = $urandom_range(0, 99);
    s = (pick < 8) ? 0 : (pick < 16) ? 255 : $urandom_range(0, 255);
    pick = $urandom_range(0, 99);
    v = (pick < 5) ? 0 : (pick < 10) ? 255 : $urandom_range(0, 255);
    queue_pixel(h, s, v, gap, stall, drain);
  endtask

  // Pixel driver and colour receiver; both change their outputs on the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      color_stall <= ($urandom_range(0, 99) < stall_pct);
      if (!pixel_valid || pixel_taken) begin
        if (pending_pixels.size() == 0) begin
          pixel_valid <= 1'b0;
        end else if (pending_pixels[0].wait_for_drain && colours_expected.size() != 0) begin
          pixel_valid <= 1'b0;
        end else if ($urandom_range(0, 99) < pending_pixels[0].gap_pct) begin
          pixel_valid <= 1'b0;
        end else begin
          next_pixel  = pending_pixels.pop_front();
          stall_pct   = next_pixel.stall_pct;
          hue         <= next_pixel.hue;
          saturation  <= next_pixel.saturation;
          value       <= next_pixel.value;
          pixel_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: predicts every accepted pixel and checks every accepted colour.
  always @(posedge clk) begin
    pixel_taken <= pixel_valid && !pixel_stall;
    if (!rst && pixel_valid && !pixel_stall) begin
      colours_expected.push_back(hsv_pixel_to_rgb(hue, saturation, value));
      pixels_converted++;
      if (hue >= HUE_LIMIT) begin
        wrapped_hues++;
      end
      if (saturation == 0) begin
        grey_pixels++;
      end
    end
    if (!rst && color_valid && !color_stall) begin
      if (colours_expected.size() == 0) begin
        $error("colour transaction with no pixel outstanding: %0d %0d %0d",
               red, green, blue);
        mismatches++;
      end else begin
        oldest_colour = colours_expected.pop_front();
        colours_checked++;
        if (!channel_matches("red", oldest_colour.red, red)) begin
          mismatches++;
        end
        if (!channel_matches("green", oldest_colour.green, green)) begin
          mismatches++;
        end
        if (!channel_matches("blue", oldest_colour.blue, blue)) begin
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles.", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned gap_by_phase[NUM_PHASES];
    int unsigned stall_by_phase[NUM_PHASES];
    gap_by_phase   = '{0, 52, 0, 14};
    stall_by_phase = '{0, 0, 52, 14};
    clk              = 1'b0;
    rst              = 1'b1;
    pixel_valid      = 1'b0;
    hue              = '0;
    saturation       = '0;
    value            = '0;
    color_stall      = 1'b0;
    pixel_taken      = 1'b0;
    stall_pct        = 0;
    cycle_count      = 0;
    mismatches       = 0;
    pixels_converted = 0;
    colours_checked  = 0;
    wrapped_hues     = 0;
    grey_pixels      = 0;

    // Sector edges, wrapped hues, grey, black and full-scale pixels.
    queue_pixel(0, 255, 255, 0, 0, 0);
    queue_pixel(59, 255, 255, 0, 0, 0);
    queue_pixel(60, 200, 180, 0, 0, 0);
    queue_pixel(119, 128, 255, 0, 0, 0);
    queue_pixel(120, 255, 200, 0, 0, 0);
    queue_pixel(179, 1, 255, 0, 0, 0);
    queue_pixel(180, 255, 100, 0, 0, 0);
    queue_pixel(239, 77, 255, 0, 0, 0);
    queue_pixel(240, 255, 255, 0, 0, 0);
    queue_pixel(299, 170, 90, 0, 0, 0);
    queue_pixel(300, 255, 255, 0, 0, 0);
    queue_pixel(359, 255, 255, 0, 0, 0);
    queue_pixel(HUE_LIMIT, 255, 255, 0, 0, 0);
    queue_pixel(512, 99, 200, 0, 0, 0);
    queue_pixel(1023, 255, 255, 0, 0, 0);
    queue_pixel(200, 0, 255, 0, 0, 0);
    queue_pixel(1023, 0, 77, 0, 0, 0);
    queue_pixel(30, 0, 0, 0, 0, 0);
    queue_pixel(90, 255, 0, 0, 0, 0);
    queue_pixel(210, 1, 1, 0, 0, 0);
    queue_pixel(330, 128, 128, 0, 0, 0);
    queue_pixel(45, 255, 1, 0, 0, 0);
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      for (int n = 0; n < RANDOM_PIXELS / NUM_PHASES; n++) begin
        queue_random_pixel(gap_by_phase[phase], stall_by_phase[phase], n == 0);
      end
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_pixels.size() != 0 || pixel_valid) begin
      @(posedge clk);
    end
    while (colours_expected.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Converted %0d pixels (%0d with wrapped hue, %0d grey) under four",
             pixels_converted, wrapped_hues, grey_pixels);
    $display("gap and stall patterns; %0d colours compared.", colours_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
